// ===== design/pru_pkg.sv =====
// Shared types and constants for the pixel replicate upscaler.
package pru_pkg;

    localparam int unsigned MAX_WIDTH_DEF = 1024;
    localparam int unsigned MAX_SCALE_DEF = 64;

    localparam int unsigned PIX_W   = 24;
    localparam int unsigned SCALE_W = 7;
    localparam int unsigned SRCW_W  = 11;
    localparam int unsigned CFG_W   = 11;
    localparam int unsigned PAD_W   = 2;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;
    localparam int unsigned Q_CNT_W = 3;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SCALE = 1'b0;
    localparam t_cfg_idx CFG_WIDTH = 1'b1;

    typedef logic [0:0] t_op;
    localparam t_op OP_PIXEL  = 1'b0;
    localparam t_op OP_REPLAY = 1'b1;

    // One command from the front end: a pixel to be copied scale times, or an error.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             row_end;
        logic [PAD_W-1:0] pad;
        logic             error;
    } t_cmd;

endpackage

// ===== design/pixel_replicate_upscaler_top.sv =====
// Top level of the pixel replicate upscaler: configuration registers and the three stages.
//
// Usage: write scale (index 0) and source width (index 1) through the plain write
// port while the block is idle; out-of-range values are clamped as they are written
// (zero acts as one, values above the maximum act as the maximum).
// Input channel: drive push with op and pixel_in; a transaction completes when push
// is high and full is low. Op 0 carries a source pixel, op 1 a replay step for the
// repeated rows; an item of the wrong kind yields a single error result and is dropped.
// Result channel: while empty is low the oldest result is on the output ports; pop
// takes it. Each good item gives scale copies, the final one marked last, and the
// final copy of an output row carries row_end and the pad byte count.
// Path: from accept to the first copy on the outputs an item passes the front register
// and line store read, the queue write, and the result register.
// Throughput: one result per cycle while pop is high, so an item occupies the back end
// for scale results (one for an error); the front accepts one item per cycle until the
// four-entry command queue fills. The back end's copy expander sets the sustained rate.
// Reset: synchronous, active low; clears row state, mode and queues, and sets both
// registers to one. The line store is not cleared.
// Stall: when pop stays low the result register holds, the back end stops and the
// queue fills; full rises and holds off further input until results drain.
module pixel_replicate_upscaler_top #(
    parameter int unsigned MAX_WIDTH = pru_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_SCALE = pru_pkg::MAX_SCALE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  pru_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [pru_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  pru_pkg::t_op                  i_op,
    input  logic [pru_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                          empty,
    input  logic                          pop,
    output logic [pru_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                          o_last,
    output logic                          o_row_end,
    output logic [pru_pkg::PAD_W-1:0]     o_pad_bytes,
    output logic                          o_error
);
    import pru_pkg::*;

    localparam int unsigned WEFF_W = $clog2(MAX_WIDTH + 1);

    // Effective (clamped) register values, held ready for both ends
    logic [SCALE_W-1:0] r_scale, n_scale;
    logic [WEFF_W-1:0]  r_width, n_width;
    logic [SCALE_W-1:0] cfg_scale;
    logic [SRCW_W-1:0]  cfg_width;

    logic               cmd_valid;
    t_cmd               cmd;
    logic               q_pop;
    logic               q_valid;
    t_cmd               q_head;
    logic [Q_CNT_W-1:0] q_count;

    assign cfg_scale = i_cfg_data[SCALE_W-1:0];
    assign cfg_width = i_cfg_data[SRCW_W-1:0];

    always_comb begin
        n_scale = r_scale;
        n_width = r_width;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCALE: begin
                    priority if (cfg_scale == '0) begin
                        n_scale = SCALE_W'(1);
                    end else if (32'(cfg_scale) > 32'(MAX_SCALE)) begin
                        n_scale = SCALE_W'(MAX_SCALE);
                    end else begin
                        n_scale = cfg_scale;
                    end
                end
                CFG_WIDTH: begin
                    priority if (cfg_width == '0) begin
                        n_width = WEFF_W'(1);
                    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
                        n_width = WEFF_W'(MAX_WIDTH);
                    end else begin
                        n_width = WEFF_W'(cfg_width);
                    end
                end
                default: begin
                    n_scale = r_scale;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_W'(1);
            r_width <= WEFF_W'(1);
        end else begin
            r_scale <= n_scale;
            r_width <= n_width;
        end
    end

    // Front: classify items, advance row state, write or read the line store
    pru_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_op        (i_op),
        .i_pixel_in  (i_pixel_in),
        .i_scale     (r_scale),
        .i_width     (r_width),
        .i_q_count   (q_count),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // Decouple the two ends so either may stall on its own
    pru_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head),
        .o_count (q_count)
    );

    // Back: replicate each good command scale times (an error once) into the result register
    pru_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scale      (r_scale),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_q_pop      (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_pixel_out  (o_pixel_out),
        .o_last       (o_last),
        .o_row_end    (o_row_end),
        .o_pad_bytes  (o_pad_bytes),
        .o_error      (o_error)
    );

endmodule

// ===== design/pru_ram.sv =====
// Generic single-port RAM with registered read.
module pru_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pru_front.sv =====
// Front end: accepts items, checks their kind, tracks row state and owns the line store.
module pru_front #(
    parameter int unsigned MAX_WIDTH = pru_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_SCALE = pru_pkg::MAX_SCALE_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_push,
    output logic                                      o_full,
    input  pru_pkg::t_op                              i_op,
    input  logic [pru_pkg::PIX_W-1:0]                 i_pixel_in,
    input  logic [pru_pkg::SCALE_W-1:0]               i_scale,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]            i_width,
    input  logic [pru_pkg::Q_CNT_W-1:0]               i_q_count,
    output logic                                      o_cmd_valid,
    output pru_pkg::t_cmd                             o_cmd
);
    import pru_pkg::*;

    localparam int unsigned COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned ROWS_W = (MAX_SCALE > 2) ? $clog2(MAX_SCALE) : 1;

    logic [COL_W-1:0]  r_column, n_column;
    logic [ROWS_W-1:0] r_rows_left, n_rows_left;
    logic              r_replaying, n_replaying;
    logic              r_s1_valid;
    logic              r_s1_rd;
    t_cmd              r_s1_cmd, n_s1_cmd;

    logic              accept;
    logic              mismatch;
    logic              row_end;
    logic [3:0]        pad_prod;
    logic [31:0]       width_x;
    logic [31:0]       scale_x;
    logic              ram_en;
    logic              ram_we;
    logic [PIX_W-1:0]  ram_rdata;

    assign o_full   = ({1'b0, i_q_count} + {{Q_CNT_W{1'b0}}, r_s1_valid})
                      >= (Q_CNT_W+1)'(Q_DEPTH);
    assign accept   = i_push & ~o_full;
    assign mismatch = (i_op == OP_REPLAY) != r_replaying;
    assign width_x  = 32'(i_width);
    assign scale_x  = 32'(i_scale);
    assign row_end  = (32'(r_column) + 32'd1) >= width_x;
    // 3*w*s padded to a word boundary: the pad count reduces to w*s mod 4
    assign pad_prod = {2'b00, width_x[1:0]} * {2'b00, scale_x[1:0]};

    assign ram_en = accept & ~mismatch;
    assign ram_we = ~r_replaying;

    pru_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (r_column),
        .i_wdata (i_pixel_in),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_column    = r_column;
        n_rows_left = r_rows_left;
        n_replaying = r_replaying;
        n_s1_cmd.pixel   = i_pixel_in;
        n_s1_cmd.row_end = row_end;
        n_s1_cmd.pad     = row_end ? pad_prod[PAD_W-1:0] : '0;
        n_s1_cmd.error   = 1'b0;
        if (mismatch) begin
            n_s1_cmd = '{pixel: '0, row_end: 1'b0, pad: '0, error: 1'b1};
        end else if (accept) begin
            if (row_end) begin
                n_column = '0;
                if (!r_replaying) begin
                    if (i_scale > 7'd1) begin
                        n_rows_left = ROWS_W'(i_scale - 7'd1);
                        n_replaying = 1'b1;
                    end
                end else begin
                    n_rows_left = r_rows_left - ROWS_W'(1);
                    if (r_rows_left == ROWS_W'(1)) begin
                        n_replaying = 1'b0;
                    end
                end
            end else begin
                n_column = r_column + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_rows_left <= '0;
            r_replaying <= 1'b0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_column    <= n_column;
            r_rows_left <= n_rows_left;
            r_replaying <= n_replaying;
            r_s1_valid  <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd <= n_s1_cmd;
            r_s1_rd  <= r_replaying & ~mismatch;
        end
    end

    // Replay steps take their pixel from the line store read issued at accept
    always_comb begin
        o_cmd = r_s1_cmd;
        if (r_s1_rd) begin
            o_cmd.pixel = ram_rdata;
        end
    end
    assign o_cmd_valid = r_s1_valid;

endmodule

// ===== design/pru_queue.sv =====
// Short command queue between the front and back ends.
module pru_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  pru_pkg::t_cmd                i_cmd,
    input  logic                         i_pop,
    output logic                         o_valid,
    output pru_pkg::t_cmd                o_head,
    output logic [pru_pkg::Q_CNT_W-1:0]  o_count
);
    import pru_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               do_pop;

    assign do_pop = i_pop & (r_count != '0);

    always_comb begin
        n_count = r_count;
        unique case ({i_push, do_pop})
            2'b10:   n_count = r_count + Q_CNT_W'(1);
            2'b01:   n_count = r_count - Q_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== design/pru_back.sv =====
// Back end: expands each command into its copies and holds the result register.
module pru_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pru_pkg::SCALE_W-1:0]   i_scale,
    input  logic                          i_head_valid,
    input  pru_pkg::t_cmd                 i_head,
    output logic                          o_q_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [pru_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                          o_last,
    output logic                          o_row_end,
    output logic [pru_pkg::PAD_W-1:0]     o_pad_bytes,
    output logic                          o_error
);
    import pru_pkg::*;

    logic [SCALE_W-1:0] r_copy, n_copy;
    logic               r_out_valid, n_out_valid;
    logic [PIX_W-1:0]   r_pixel;
    logic               r_last, r_row_end, r_error;
    logic [PAD_W-1:0]   r_pad;
    logic               load;
    logic               fin;

    assign load = i_head_valid & (~r_out_valid | i_pop);
    assign fin  = i_head.error | ((r_copy + SCALE_W'(1)) == i_scale);

    always_comb begin
        n_copy      = r_copy;
        n_out_valid = r_out_valid;
        if (load) begin
            n_copy      = fin ? '0 : r_copy + SCALE_W'(1);
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_copy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_copy      <= n_copy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pixel   <= i_head.pixel;
            r_last    <= fin;
            r_row_end <= fin & i_head.row_end;
            r_pad     <= (fin & i_head.row_end) ? i_head.pad : '0;
            r_error   <= i_head.error;
        end
    end

    assign o_q_pop     = load & fin;
    assign o_empty     = ~r_out_valid;
    assign o_pixel_out = r_pixel;
    assign o_last      = r_last;
    assign o_row_end   = r_row_end;
    assign o_pad_bytes = r_pad;
    assign o_error     = r_error;

endmodule
